>>> rtl/assert_macros.svh
// Assertion helper macros used by ptld_cell.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PTLD_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ptld assertion failed");

// Next-cycle implication.
`define PTLD_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ptld assertion failed");

`endif

>>> rtl/ptld_pkg.sv
// Shared constants for the point-to-line distance block.
// No dependencies.
package ptld_pkg;
   localparam int DIST_WIDTH = 25;  // result width, fixed point
   localparam int FRONT_STAGES = 5; // pipeline depth ahead of the root cells
endpackage

>>> rtl/ptld_front.sv
// Front pipeline: differences, cross product, squared norms, scaled radicand.
// Depends on ptld_pkg.
module ptld_front #(
   parameter int CW = 16,
   parameter int FB = 8,
   parameter int DENW = 35,
   parameter int W = 120
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [CW-1:0]        a_x, a_y, a_z,
   input  logic [CW-1:0]        b_x, b_y, b_z,
   input  logic [CW-1:0]        s_x, s_y, s_z,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [W-1:0]         out_res,
   output logic [DENW-1:0]      out_den,
   output logic                 out_degen
);
   localparam int CW1  = CW + 1;
   localparam int PW   = 2 * CW + 2;
   localparam int CRW  = 2 * CW + 3;
   localparam int MAGW = 2 * CW + 2;
   localparam int H    = (MAGW + 1) / 2;
   localparam int HIW  = MAGW - H;
   localparam int NUMW = 2 * MAGW + 2;
   localparam int NS   = ptld_pkg::FRONT_STAGES;

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   rdy;

   // stage 1
   logic signed [CW1-1:0] u_ff [3], u_in [3];
   logic signed [CW1-1:0] w_ff [3], w_in [3];
   // stage 2
   logic signed [PW-1:0]  x_ff [6], x_in [6];
   logic signed [PW-1:0]  vv_ff [3], vv_in [3];
   logic signed [PW-1:0]  uu_ff [3], uu_in [3];
   // stage 3
   logic [MAGW-1:0] mag_ff [3], mag_in [3];
   logic [DENW-1:0] den3_ff, den3_in, us3_ff, us3_in;
   logic            dg3_ff, dg3_in;
   // stage 4
   logic [2*HIW-1:0] hh_ff [3], hh_in [3];
   logic [MAGW-1:0]  hl_ff [3], hl_in [3];
   logic [2*H-1:0]   ll_ff [3], ll_in [3];
   logic [DENW-1:0]  den4_ff, us4_ff;
   logic             dg4_ff;
   // stage 5
   logic [W-1:0]    res_ff, res_in;
   logic [DENW-1:0] den5_ff, den5_in;
   logic            dg5_ff;

   logic [CW-1:0] av [3], bv [3], sv [3];
   logic [NUMW-1:0] num;

   always_comb begin
      av = '{a_x, a_y, a_z};
      bv = '{b_x, b_y, b_z};
      sv = '{s_x, s_y, s_z};
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in = {v_ff[NS-2:0], in_valid};
      for (int i = 0; i < 3; i++) begin
         u_in[i] = $signed({sv[i][CW-1], sv[i]}) - $signed({av[i][CW-1], av[i]});
         w_in[i] = $signed({bv[i][CW-1], bv[i]}) - $signed({av[i][CW-1], av[i]});
         vv_in[i] = w_ff[i] * w_ff[i];
         uu_in[i] = u_ff[i] * u_ff[i];
         // u_j * w_k and u_k * w_j for component i
         x_in[2*i]   = u_ff[(i+1)%3] * w_ff[(i+2)%3];
         x_in[2*i+1] = u_ff[(i+2)%3] * w_ff[(i+1)%3];
      end
      for (int i = 0; i < 3; i++) begin
         logic signed [CRW-1:0] c;
         logic [CRW-1:0] ca;
         c = $signed({x_ff[2*i][PW-1], x_ff[2*i]})
           - $signed({x_ff[2*i+1][PW-1], x_ff[2*i+1]});
         ca = c[CRW-1] ? CRW'(-c) : CRW'(c);
         mag_in[i] = ca[MAGW-1:0];
      end
      den3_in = DENW'({1'b0, vv_ff[0]}) + DENW'({1'b0, vv_ff[1]})
              + DENW'({1'b0, vv_ff[2]});
      us3_in  = DENW'({1'b0, uu_ff[0]}) + DENW'({1'b0, uu_ff[1]})
              + DENW'({1'b0, uu_ff[2]});
      dg3_in  = (den3_in == '0);
      for (int i = 0; i < 3; i++) begin
         hh_in[i] = (2*HIW)'(mag_ff[i][MAGW-1:H]) * (2*HIW)'(mag_ff[i][MAGW-1:H]);
         hl_in[i] = MAGW'(mag_ff[i][MAGW-1:H]) * MAGW'(mag_ff[i][H-1:0]);
         ll_in[i] = (2*H)'(mag_ff[i][H-1:0]) * (2*H)'(mag_ff[i][H-1:0]);
      end
      num = '0;
      for (int i = 0; i < 3; i++) begin
         num = num + (NUMW'(hh_ff[i]) << (2*H)) + (NUMW'(hl_ff[i]) << (H+1))
             + NUMW'(ll_ff[i]);
      end
      // degenerate line: measure point to point, divide by one
      res_in  = dg4_ff ? (W'(us4_ff) << (2*FB)) : (W'(num) << (2*FB));
      den5_in = dg4_ff ? DENW'(1) : den4_ff;
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_res   = res_ff;
   assign out_den   = den5_ff;
   assign out_degen = dg5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) v_ff[k] <= v_in[k];
         end
      end
      if (rdy[0]) begin
         u_ff <= u_in;
         w_ff <= w_in;
      end
      if (rdy[1]) begin
         x_ff  <= x_in;
         vv_ff <= vv_in;
         uu_ff <= uu_in;
      end
      if (rdy[2]) begin
         mag_ff  <= mag_in;
         den3_ff <= den3_in;
         us3_ff  <= us3_in;
         dg3_ff  <= dg3_in;
      end
      if (rdy[3]) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         den4_ff <= den3_ff;
         us4_ff  <= us3_ff;
         dg4_ff  <= dg3_ff;
      end
      if (rdy[4]) begin
         res_ff  <= res_in;
         den5_ff <= den5_in;
         dg5_ff  <= dg4_ff;
      end
   end
endmodule

>>> rtl/ptld_cell.sv
// One root cell: decides one result bit and passes the item on.
// Depends on ptld_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ptld_cell #(
   parameter int BIT = 0,
   parameter int DENW = 35,
   parameter int W = 120
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [W-1:0]                   in_res,
   input  logic [W-1:0]                   in_p,
   input  logic [DENW-1:0]                in_den,
   input  logic [ptld_pkg::DIST_WIDTH-1:0] in_r,
   input  logic                           in_degen,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [W-1:0]                   out_res,
   output logic [W-1:0]                   out_p,
   output logic [DENW-1:0]                out_den,
   output logic [ptld_pkg::DIST_WIDTH-1:0] out_r,
   output logic                           out_degen
);
   localparam int DW = ptld_pkg::DIST_WIDTH;
   localparam logic [DW-1:0] ONE = DW'(1);

   logic          valid_ff;
   logic [W-1:0]  res_ff, res_in, p_ff, p_in, delta;
   logic [DENW-1:0] den_ff;
   logic [DW-1:0] r_ff, r_in;
   logic          degen_ff;

   // (r + 2^b)^2 d - r^2 d = (r d) 2^(b+1) + d 2^(2b)
   always_comb begin
      delta = (in_p << (BIT + 1)) + (W'(in_den) << (2 * BIT));
      if (delta <= in_res) begin
         res_in = in_res - delta;
         p_in   = in_p + (W'(in_den) << BIT);
         r_in   = in_r | (ONE << BIT);
      end else begin
         res_in = in_res;
         p_in   = in_p;
         r_in   = in_r;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_p     = p_ff;
   assign out_den   = den_ff;
   assign out_r     = r_ff;
   assign out_degen = degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         res_ff   <= res_in;
         p_ff     <= p_in;
         den_ff   <= in_den;
         r_ff     <= r_in;
         degen_ff <= in_degen;
      end
   end

   `PTLD_ASSERT_NOW(a_low_bits_open, clock, reset, valid_ff, (r_ff & ((ONE << BIT) - ONE)) == '0)
   `PTLD_ASSERT_NOW(a_den_nonzero, clock, reset, valid_ff, den_ff != '0)
   `PTLD_ASSERT_NEXT(a_hold, clock, reset, valid_ff && !out_ready, valid_ff && $stable(r_ff))
endmodule

>>> rtl/point_to_line_distance_3d_top.sv
// Distance from probe point S to the 3D line through A and B, as unsigned
// fixed point with FRAC_BITS fraction bits, floored. One item enters per
// cycle when nothing downstream stalls; an item passes 5 front stages, 25 root
// cells and one output register in turn. The front pipeline forms S-A,
// B-A, the cross product, |B-A|^2 and the radicand; each root cell settles
// one result bit with shifts and a compare-subtract, so no divider is used.
// When A equals B the degenerate flag is set and |S-A| is returned. Results
// saturate at the all-ones 25-bit value. Every stage holds its item under
// stall while upstream bubbles still collapse. Depends on ptld_pkg,
// ptld_front, ptld_cell.
module point_to_line_distance_3d_top #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [COORD_WIDTH-1:0]          req_line_a_x,
   input  logic [COORD_WIDTH-1:0]          req_line_a_y,
   input  logic [COORD_WIDTH-1:0]          req_line_a_z,
   input  logic [COORD_WIDTH-1:0]          req_line_b_x,
   input  logic [COORD_WIDTH-1:0]          req_line_b_y,
   input  logic [COORD_WIDTH-1:0]          req_line_b_z,
   input  logic [COORD_WIDTH-1:0]          req_probe_x,
   input  logic [COORD_WIDTH-1:0]          req_probe_y,
   input  logic [COORD_WIDTH-1:0]          req_probe_z,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ptld_pkg::DIST_WIDTH-1:0] rsp_distance,
   output logic                            rsp_degenerate
);
   localparam int DW   = ptld_pkg::DIST_WIDTH;
   localparam int DENW = 2 * COORD_WIDTH + 3;
   localparam int NUMW = 4 * COORD_WIDTH + 6;
   localparam int RW   = NUMW + 2 * FRAC_BITS;
   localparam int PW   = DENW + 2 * DW + 1;
   // wide enough for the radicand and for every trial delta
   localparam int W    = ((RW > PW) ? RW : PW) + 1;

   logic            vld [DW+1];
   logic            rdy [DW+1];
   logic [W-1:0]    res [DW+1];
   logic [W-1:0]    pp  [DW+1];
   logic [DENW-1:0] den [DW+1];
   logic [DW-1:0]   rr  [DW+1];
   logic            dg  [DW+1];

   logic            front_ready;
   logic            rsp_valid_ff;
   logic [DW-1:0]   dist_ff;
   logic            degen_ff;

   ptld_front #(
      .CW(COORD_WIDTH), .FB(FRAC_BITS), .DENW(DENW), .W(W)
   ) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(front_ready),
      .a_x(req_line_a_x), .a_y(req_line_a_y), .a_z(req_line_a_z),
      .b_x(req_line_b_x), .b_y(req_line_b_y), .b_z(req_line_b_z),
      .s_x(req_probe_x), .s_y(req_probe_y), .s_z(req_probe_z),
      .out_valid(vld[0]), .out_ready(rdy[0]),
      .out_res(res[0]), .out_den(den[0]), .out_degen(dg[0])
   );

   // root starts from zero: no bits set, no partial product
   assign pp[0] = '0;
   assign rr[0] = '0;

   // cell i settles result bit DW-1-i, most significant first
   for (genvar i = 0; i < DW; i++) begin : g_cell
      ptld_cell #(.BIT(DW - 1 - i), .DENW(DENW), .W(W)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(vld[i]), .in_ready(rdy[i]),
         .in_res(res[i]), .in_p(pp[i]), .in_den(den[i]), .in_r(rr[i]),
         .in_degen(dg[i]),
         .out_valid(vld[i+1]), .out_ready(rdy[i+1]),
         .out_res(res[i+1]), .out_p(pp[i+1]), .out_den(den[i+1]),
         .out_r(rr[i+1]), .out_degen(dg[i+1])
      );
   end

   // output register: advance when empty or when the consumer takes the item
   assign rdy[DW] = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy[DW]) begin
         rsp_valid_ff <= vld[DW];
      end
      if (rdy[DW]) begin
         dist_ff  <= rr[DW];
         degen_ff <= dg[DW];
      end
   end

   assign req_stall      = !front_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = dist_ff;
   assign rsp_degenerate = degen_ff;
endmodule

>>> bench/tb_point_to_line_distance_3d_top.sv
// Self-checking bench for the point-to-line distance block: directed table, then random items.
// Expected results come from an exact integer predictor; depends on ptld_pkg and the top RTL.
`timescale 1ns / 100ps

module tb_point_to_line_distance_3d_top;

   localparam int CW = 16;
   localparam int FB = 8;
   localparam int LATENCY = 31;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1030;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type ax, ay, az, bx, by, bz, sx, sy, sz;
   } query_type;

   typedef struct packed {
      logic [ptld_pkg::DIST_WIDTH-1:0] distance;
      logic                            degenerate;
   } answer_type;

   // Directed row: query plus an optional typed-in answer.
   typedef struct {
      query_type  q;
      bit         typed;
      answer_type ans;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_line_a_x = '0, req_line_a_y = '0, req_line_a_z = '0;
   coord_type req_line_b_x = '0, req_line_b_y = '0, req_line_b_z = '0;
   coord_type req_probe_x = '0, req_probe_y = '0, req_probe_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [ptld_pkg::DIST_WIDTH-1:0] rsp_distance;
   logic rsp_degenerate;

   answer_type pending_answers[$];
   int errors = 0;
   int idle_cycles = 0;
   bit stim_done = 0;

   point_to_line_distance_3d_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_line_a_x, .req_line_a_y, .req_line_a_z,
      .req_line_b_x, .req_line_b_y, .req_line_b_z,
      .req_probe_x, .req_probe_y, .req_probe_z,
      .rsp_valid, .rsp_stall, .rsp_distance, .rsp_degenerate
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Exact distance: largest r with r^2 * |B-A|^2 <= 2^(2F) * |(S-A)x(B-A)|^2; for A = B, r^2 <= 2^(2F) * |S-A|^2.
   function automatic answer_type line_distance(query_type q);
      logic signed [127:0] u[3], v[3], c;
      logic [255:0] num, den, cand, trial;
      logic [ptld_pkg::DIST_WIDTH-1:0] root;
      answer_type a;
      u[0] = 128'(q.sx) - 128'(q.ax); v[0] = 128'(q.bx) - 128'(q.ax);
      u[1] = 128'(q.sy) - 128'(q.ay); v[1] = 128'(q.by) - 128'(q.ay);
      u[2] = 128'(q.sz) - 128'(q.az); v[2] = 128'(q.bz) - 128'(q.az);
      den = 256'(v[0] * v[0]) + 256'(v[1] * v[1]) + 256'(v[2] * v[2]);
      num = '0;
      a.degenerate = (den == '0);
      if (a.degenerate) begin
         for (int i = 0; i < 3; i++) num += 256'(u[i] * u[i]);
         den = 256'(1);
      end else begin
         for (int i = 0; i < 3; i++) begin
            c = u[(i+1)%3] * v[(i+2)%3] - u[(i+2)%3] * v[(i+1)%3];
            num += 256'(c * c);
         end
      end
      num = num << (2 * FB);
      root = '0;
      for (int b = ptld_pkg::DIST_WIDTH - 1; b >= 0; b--) begin
         cand = 256'(root | (ptld_pkg::DIST_WIDTH'(1) << b));
         trial = cand * cand * den;
         if (trial <= num) root[b] = 1'b1;
      end
      a.distance = root;
      return a;
   endfunction

   function automatic query_type random_query();
      query_type q;
      int mode;
      mode = $urandom_range(0, 9);
      {q.ax, q.ay, q.az} = (3*CW)'({$urandom, $urandom});
      {q.bx, q.by, q.bz} = (3*CW)'({$urandom, $urandom});
      {q.sx, q.sy, q.sz} = (3*CW)'({$urandom, $urandom});
      case (mode)
         0: begin // coincident line points
            q.bx = q.ax; q.by = q.ay; q.bz = q.az;
         end
         1: begin // probe on A
            q.sx = q.ax; q.sy = q.ay; q.sz = q.az;
         end
         2: begin // short line, small offsets
            q.bx = coord_type'(q.ax + coord_type'($urandom_range(0, 6)) - 3);
            q.by = coord_type'(q.ay + coord_type'($urandom_range(0, 6)) - 3);
            q.bz = coord_type'(q.az + coord_type'($urandom_range(0, 6)) - 3);
         end
         3: begin // probe on B
            q.sx = q.bx; q.sy = q.by; q.sz = q.bz;
         end
         default: ;
      endcase
      return q;
   endfunction

   row_type directed[$];

   task automatic add_row(query_type q, bit typed = 0, int dist_val = 0, bit degen = 0);
      row_type r;
      r.q = q; r.typed = typed;
      r.ans.distance = ptld_pkg::DIST_WIDTH'(dist_val); r.ans.degenerate = degen;
      directed.push_back(r);
   endtask

   function automatic query_type mk(int ax, int ay, int az, int bx, int by, int bz,
                                    int sx, int sy, int sz);
      query_type q;
      q.ax = coord_type'(ax); q.ay = coord_type'(ay); q.az = coord_type'(az);
      q.bx = coord_type'(bx); q.by = coord_type'(by); q.bz = coord_type'(bz);
      q.sx = coord_type'(sx); q.sy = coord_type'(sy); q.sz = coord_type'(sz);
      return q;
   endfunction

   // Offer one item and hold it until accepted; idle at random beforehand.
   task automatic send_item(query_type q, bit may_idle);
      while (may_idle && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_line_a_x, req_line_a_y, req_line_a_z} <= {q.ax, q.ay, q.az};
      {req_line_b_x, req_line_b_y, req_line_b_z} <= {q.bx, q.by, q.bz};
      {req_probe_x, req_probe_y, req_probe_z} <= {q.sx, q.sy, q.sz};
      do @(posedge clock); while (req_stall);
   endtask

   // Stimulus.
   initial begin
      int lo, hi;
      lo = -32768; hi = 32767;
      add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1);
      add_row(mk(5, 5, 5, 5, 5, 5, 8, 9, 5), 1, 5 * 256, 1);
      add_row(mk(1, 2, 3, 7, 8, 9, 1, 2, 3), 1, 0, 0);
      add_row(mk(0, 0, 0, 10, 0, 0, 4, 3, 0), 1, 3 * 256, 0);
      add_row(mk(0, 0, 0, 0, 0, 1, 0, 7, 100), 1, 7 * 256, 0);
      add_row(mk(lo, lo, lo, lo, lo, lo, hi, hi, hi), 0);
      add_row(mk(hi, hi, hi, hi, hi, hi, lo, lo, lo), 0);
      add_row(mk(lo, lo, lo, hi, hi, hi, lo, hi, lo), 0);
      add_row(mk(lo, 0, 0, hi, 0, 0, 0, hi, hi), 0);
      add_row(mk(lo, lo, 0, lo, lo, 1, hi, hi, 0), 0);
      add_row(mk(hi, lo, hi, lo, hi, lo, hi, hi, lo), 0);
      add_row(mk(-1, -1, -1, 0, 0, 0, 1, 1, 1), 0);
      add_row(mk(0, 0, 0, 1, 1, 1, 1, 0, 0), 0);
      add_row(mk(0, 0, 0, 3, 4, 0, 0, 0, 5), 0);
      add_row(mk(-7, 2, 9, 100, -300, 42, 7, 7, 7), 0);
      add_row(mk(lo, lo, lo, lo + 1, lo, lo, hi, hi, hi), 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         answer_type a;
         a = line_distance(directed[i].q);
         if (directed[i].typed && a != directed[i].ans) begin
            $error("typed answer disagrees with predictor on row %0d", i);
            errors++;
         end
         pending_answers.push_back(directed[i].typed ? directed[i].ans : a);
         send_item(directed[i].q, 1);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         query_type q;
         q = random_query();
         pending_answers.push_back(line_distance(q));
         // No idling in a long middle stretch.
         send_item(q, !(n >= 300 && n < 500));
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // Receiver: random stall, a clean stretch, and one long hold-off to fill the pipe.
   initial begin
      int cyc;
      cyc = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= 200 && cyc < 320)
            rsp_stall <= 1'b1;              // hold off long enough to back up the input
         else if (cyc >= 700 && cyc < 1000)
            rsp_stall <= 1'b0;              // stretch with no stall
         else
            rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result: distance %0d degenerate %0b", rsp_distance,
                   rsp_degenerate);
            errors++;
         end else begin
            answer_type e;
            e = pending_answers.pop_front();
            if (rsp_distance !== e.distance) begin
               $error("distance: expected %0d actual %0d", e.distance, rsp_distance);
               errors++;
            end
            if (rsp_degenerate !== e.degenerate) begin
               $error("degenerate: expected %0b actual %0b", e.degenerate, rsp_degenerate);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles with no accepted item on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // End of run.
   initial begin
      wait (!reset);
      fork
         begin
            wait (stim_done && pending_answers.size() == 0);
            repeat (LATENCY + 10) @(posedge clock);
         end
         begin
            wait (idle_cycles >= WATCHDOG_LIMIT);
            errors++;
            $display("timeout with %0d results outstanding", pending_answers.size());
         end
      join_any
      if (errors == 0 && pending_answers.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> point_to_line_distance_3d_top.f
+incdir+rtl
rtl/ptld_pkg.sv
rtl/ptld_front.sv
rtl/ptld_cell.sv
rtl/point_to_line_distance_3d_top.sv
bench/tb_point_to_line_distance_3d_top.sv
